/* src/plbu_pkg.sv */
package plbu_pkg;

	localparam int LEVELS_DEF     = 64;
	localparam int PRICE_BITS_DEF = 32;
	localparam int SIZE_BITS_DEF  = 32;

	localparam int PRICE_W  = 32;
	localparam int SIZE_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_DELETED  = 3'd2,
		ST_ABSENT   = 3'd3,
		ST_IGNORED  = 3'd4,
		ST_FULL     = 3'd5,
		ST_LOOKUP   = 3'd6
	} status_t;

	localparam logic [1:0] SIDE_BID = 2'd0;
	localparam logic [1:0] SIDE_ASK = 2'd1;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic go;
		logic update;
		logic rd_en;
	} side_cmd_t;

	typedef struct packed {
		logic hit;
		logic full;
	} side_rsp_t;

endpackage

/* src/plbu_ram.sv */
module plbu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/plbu_side.sv */
module plbu_side #(
	parameter int LEVELS = plbu_pkg::LEVELS_DEF,
	parameter int KEY_W  = plbu_pkg::PRICE_BITS_DEF,
	parameter int SZ_W   = plbu_pkg::SIZE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  plbu_pkg::side_cmd_t         cmd,
	input  logic [KEY_W-1:0]            key,
	input  logic [SZ_W-1:0]             qty,
	output plbu_pkg::side_rsp_t         rsp,
	output logic [$clog2(LEVELS+1)-1:0] count_nxt,
	output logic [SZ_W-1:0]             rd_size
);

	localparam int IDX_W = $clog2(LEVELS);
	localparam int CNT_W = $clog2(LEVELS + 1);

	logic [KEY_W-1:0]  keys_q [LEVELS];
	logic [LEVELS-1:0] valid_q;
	logic [CNT_W-1:0]  count_q;

	logic [LEVELS-1:0] match;
	logic [LEVELS-1:0] free_vec;
	logic [LEVELS-1:0] free_low;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  free_idx;
	logic              hit;
	logic              full;
	logic              qty_zero;
	logic              do_del;
	logic              do_upd;
	logic              do_ins;

	always_comb begin
		match    = '0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < LEVELS; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == key);
		end
		free_vec = ~valid_q;
		free_low = free_vec & ((~free_vec) + LEVELS'(1));
		for (int i = 0; i < LEVELS; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			if (free_low[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	assign hit      = |match;
	assign full     = &valid_q;
	assign qty_zero = (qty == '0);
	assign do_del   = cmd.go && cmd.update && qty_zero && hit;
	assign do_upd   = cmd.go && cmd.update && !qty_zero && hit;
	assign do_ins   = cmd.go && cmd.update && !qty_zero && !hit && !full;

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_del) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign rsp.hit  = hit;
	assign rsp.full = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (do_del) begin
				valid_q[hit_idx] <= 1'b0;
			end else if (do_ins) begin
				valid_q[free_idx] <= 1'b1;
			end
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins) begin
			keys_q[free_idx] <= key;
		end
	end

	plbu_ram #(
		.WIDTH(SZ_W),
		.DEPTH(LEVELS)
	) u_sizes (
		.clk  (clk),
		.we   (do_upd || do_ins),
		.waddr(hit ? hit_idx : free_idx),
		.wdata(qty),
		.re   (cmd.rd_en),
		.raddr(hit_idx),
		.rdata(rd_size)
	);

endmodule

/* src/price_level_book_update.sv */
// Price-level book with one bid table and one ask table of LEVELS levels each. An update
// word inserts, overwrites or (with zero quantity) deletes the level at a price; a lookup
// word reports the stored size. Each word yields one result word carrying status, whether
// the price was present, its prior size and the level count of that side. The block takes
// one word per cycle while the result is not stalled. A word passes through the input
// register and then the result register, with the parallel key compare across all
// levels of a side done combinationally between them. The sizes are held in a RAM whose
// registered read lines up with the result register. While the result is stalled the
// block holds two words and then stalls its input. Valid marks clear at reset, so no
// clearing pass is needed.
module price_level_book_update #(
	parameter int LEVELS     = plbu_pkg::LEVELS_DEF,
	parameter int PRICE_BITS = plbu_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS  = plbu_pkg::SIZE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           kind,
	input  logic [1:0]                     book_side,
	input  logic [plbu_pkg::PRICE_W-1:0]   price,
	input  logic [plbu_pkg::SIZE_W-1:0]    quantity,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [plbu_pkg::STATUS_W-1:0]  status,
	output logic                           found,
	output logic [plbu_pkg::SIZE_W-1:0]    found_size,
	output logic [plbu_pkg::COUNT_W-1:0]   level_count
);

	localparam int PRICE_IN_W = plbu_pkg::PRICE_W;
	localparam int SIZE_OUT_W = plbu_pkg::SIZE_W;
	localparam int COUNT_O_W  = plbu_pkg::COUNT_W;
	localparam int KEY_W      = (PRICE_BITS < PRICE_IN_W) ? PRICE_BITS : PRICE_IN_W;
	localparam int SZ_W       = (SIZE_BITS < SIZE_OUT_W) ? SIZE_BITS : SIZE_OUT_W;
	localparam int CNT_W      = $clog2(LEVELS + 1);

	logic                     v1_q;
	logic                     kind_s1;
	logic [1:0]               side_s1;
	logic [PRICE_IN_W-1:0]    price_s1;
	logic [SIZE_OUT_W-1:0]    qty_s1;

	logic                     v2_q;
	plbu_pkg::status_t        status_s2;
	logic                     found_s2;
	logic                     ask_s2;
	logic [COUNT_O_W-1:0]     count_s2;

	logic                     adv;
	logic                     accept;
	logic                     is_bid;
	logic                     is_ask;
	logic [KEY_W-1:0]         key;
	logic [SZ_W-1:0]          qty;

	plbu_pkg::side_cmd_t      bid_cmd;
	plbu_pkg::side_cmd_t      ask_cmd;
	plbu_pkg::side_rsp_t      bid_rsp;
	plbu_pkg::side_rsp_t      ask_rsp;
	plbu_pkg::side_rsp_t      sel_rsp;
	logic [CNT_W-1:0]         bid_cnt;
	logic [CNT_W-1:0]         ask_cnt;
	logic [CNT_W-1:0]         sel_cnt;
	logic [CNT_W+COUNT_O_W-1:0] cnt_ext;
	logic [SZ_W-1:0]          bid_rd;
	logic [SZ_W-1:0]          ask_rd;
	logic [SZ_W-1:0]          sel_rd;

	plbu_pkg::status_t        status_c;
	logic                     found_c;
	logic [COUNT_O_W-1:0]     count_c;

	assign adv        = !v2_q || !result_stall;
	assign item_stall = v1_q && !adv;
	assign accept     = item_valid && !item_stall;

	assign is_bid = (side_s1 == plbu_pkg::SIDE_BID);
	assign is_ask = (side_s1 == plbu_pkg::SIDE_ASK);
	assign key    = price_s1[KEY_W-1:0];
	assign qty    = qty_s1[SZ_W-1:0];

	assign bid_cmd.go     = adv && v1_q && is_bid;
	assign bid_cmd.update = (kind_s1 == plbu_pkg::KIND_UPDATE);
	assign bid_cmd.rd_en  = adv;
	assign ask_cmd.go     = adv && v1_q && is_ask;
	assign ask_cmd.update = (kind_s1 == plbu_pkg::KIND_UPDATE);
	assign ask_cmd.rd_en  = adv;

	plbu_side #(
		.LEVELS(LEVELS),
		.KEY_W (KEY_W),
		.SZ_W  (SZ_W)
	) u_bid (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (bid_cmd),
		.key      (key),
		.qty      (qty),
		.rsp      (bid_rsp),
		.count_nxt(bid_cnt),
		.rd_size  (bid_rd)
	);

	plbu_side #(
		.LEVELS(LEVELS),
		.KEY_W (KEY_W),
		.SZ_W  (SZ_W)
	) u_ask (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ask_cmd),
		.key      (key),
		.qty      (qty),
		.rsp      (ask_rsp),
		.count_nxt(ask_cnt),
		.rd_size  (ask_rd)
	);

	assign sel_rsp = is_ask ? ask_rsp : bid_rsp;
	assign sel_cnt = is_ask ? ask_cnt : bid_cnt;
	assign cnt_ext = (CNT_W + COUNT_O_W)'(sel_cnt);

	always_comb begin
		status_c = plbu_pkg::ST_IGNORED;
		found_c  = 1'b0;
		count_c  = '0;
		if (is_bid || is_ask) begin
			found_c = sel_rsp.hit;
			count_c = cnt_ext[COUNT_O_W-1:0];
			if (kind_s1 == plbu_pkg::KIND_LOOKUP) begin
				status_c = plbu_pkg::ST_LOOKUP;
			end else if (qty == '0) begin
				if (sel_rsp.hit) begin
					status_c = plbu_pkg::ST_DELETED;
				end else begin
					status_c = plbu_pkg::ST_ABSENT;
				end
			end else if (sel_rsp.hit) begin
				status_c = plbu_pkg::ST_UPDATED;
			end else if (sel_rsp.full) begin
				status_c = plbu_pkg::ST_FULL;
			end else begin
				status_c = plbu_pkg::ST_INSERTED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (adv) begin
				v1_q <= 1'b0;
			end
			if (adv) begin
				v2_q <= v1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			side_s1  <= book_side;
			price_s1 <= price;
			qty_s1   <= quantity;
		end
		if (adv && v1_q) begin
			status_s2 <= status_c;
			found_s2  <= found_c;
			ask_s2    <= is_ask;
			count_s2  <= count_c;
		end
	end

	assign sel_rd       = ask_s2 ? ask_rd : bid_rd;
	assign result_valid = v2_q;
	assign status       = status_s2;
	assign found        = found_s2;
	assign found_size   = found_s2 ? SIZE_OUT_W'(sel_rd) : '0;
	assign level_count  = count_s2;

endmodule

/* tb/sv/tb_price_level_book_update.sv */
module tb_price_level_book_update;
	timeunit 1ns;
	timeprecision 1ps;

	import plbu_pkg::*;

	localparam int BOOK_LEVELS = LEVELS_DEF;
	localparam logic [1:0] SIDE_OTHER_LO = 2'd2;
	localparam logic [1:0] SIDE_OTHER_HI = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int KEY_POOL_N = 100;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_WORDS = 230;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIR_N = 21;

	typedef struct packed {
		status_t                st;
		logic                   fnd;
		logic [SIZE_W-1:0]      fsize;
		logic [COUNT_W-1:0]     cnt;
	} book_result_t;

	typedef struct packed {
		logic                   typed;
		logic                   k;
		logic [1:0]             sd;
		logic [PRICE_W-1:0]     px;
		logic [SIZE_W-1:0]      qty;
		book_result_t           res;
	} book_row_t;

	localparam book_row_t DIR_ROWS [DIR_N] = '{
		'{1'b1, KIND_LOOKUP, SIDE_BID, 32'h0, 32'h0, '{ST_LOOKUP, 1'b0, 32'h0, 7'd0}},
		'{1'b1, KIND_LOOKUP, SIDE_ASK, 32'hFFFFFFFF, 32'h0, '{ST_LOOKUP, 1'b0, 32'h0, 7'd0}},
		'{1'b1, KIND_UPDATE, SIDE_OTHER_LO, 32'h5, 32'h7, '{ST_IGNORED, 1'b0, 32'h0, 7'd0}},
		'{1'b1, KIND_LOOKUP, SIDE_OTHER_HI, 32'h5, 32'h0, '{ST_IGNORED, 1'b0, 32'h0, 7'd0}},
		'{1'b1, KIND_UPDATE, SIDE_BID, 32'd100, 32'h0, '{ST_ABSENT, 1'b0, 32'h0, 7'd0}},
		'{1'b1, KIND_UPDATE, SIDE_BID, 32'h0, 32'hFFFFFFFF, '{ST_INSERTED, 1'b0, 32'h0, 7'd1}},
		'{1'b1, KIND_UPDATE, SIDE_BID, 32'hFFFFFFFF, 32'h1, '{ST_INSERTED, 1'b0, 32'h0, 7'd2}},
		'{1'b1, KIND_LOOKUP, SIDE_BID, 32'h0, 32'h0,
			'{ST_LOOKUP, 1'b1, 32'hFFFFFFFF, 7'd2}},
		'{1'b1, KIND_UPDATE, SIDE_BID, 32'hFFFFFFFF, 32'h80000000,
			'{ST_UPDATED, 1'b1, 32'h1, 7'd2}},
		'{1'b1, KIND_UPDATE, SIDE_ASK, 32'hFFFFFFFF, 32'hFFFFFFFF,
			'{ST_INSERTED, 1'b0, 32'h0, 7'd1}},
		'{1'b1, KIND_LOOKUP, SIDE_ASK, 32'h0, 32'h0, '{ST_LOOKUP, 1'b0, 32'h0, 7'd1}},
		'{1'b1, KIND_UPDATE, SIDE_BID, 32'h0, 32'h0, '{ST_DELETED, 1'b1, 32'hFFFFFFFF, 7'd1}},
		'{1'b1, KIND_UPDATE, SIDE_BID, 32'h0, 32'h0, '{ST_ABSENT, 1'b0, 32'h0, 7'd1}},
		'{1'b1, KIND_LOOKUP, SIDE_BID, 32'hFFFFFFFF, 32'h0,
			'{ST_LOOKUP, 1'b1, 32'h80000000, 7'd1}},
		'{1'b1, KIND_UPDATE, SIDE_BID, 32'h0, 32'h5, '{ST_INSERTED, 1'b0, 32'h0, 7'd2}},
		'{1'b1, KIND_UPDATE, SIDE_OTHER_HI, 32'hFFFFFFFF, 32'h0,
			'{ST_IGNORED, 1'b0, 32'h0, 7'd0}},
		'{1'b1, KIND_UPDATE, SIDE_ASK, 32'hFFFFFFFF, 32'h0,
			'{ST_DELETED, 1'b1, 32'hFFFFFFFF, 7'd0}},
		'{1'b1, KIND_LOOKUP, SIDE_ASK, 32'hFFFFFFFF, 32'h0, '{ST_LOOKUP, 1'b0, 32'h0, 7'd0}},
		'{1'b0, KIND_UPDATE, SIDE_ASK, 32'h5555AAAA, 32'hAAAA5555,
			'{ST_INSERTED, 1'b0, 32'h0, 7'd0}},
		'{1'b0, KIND_LOOKUP, SIDE_ASK, 32'h5555AAAA, 32'h0, '{ST_LOOKUP, 1'b0, 32'h0, 7'd0}},
		'{1'b0, KIND_UPDATE, SIDE_ASK, 32'h5555AAAA, 32'h0, '{ST_DELETED, 1'b0, 32'h0, 7'd0}}
	};

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic                   kind = KIND_UPDATE;
	logic [1:0]             book_side = SIDE_BID;
	logic [PRICE_W-1:0]     price = '0;
	logic [SIZE_W-1:0]      quantity = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [STATUS_W-1:0]    status;
	logic                   found;
	logic [SIZE_W-1:0]      found_size;
	logic [COUNT_W-1:0]     level_count;

	logic [PRICE_W-1:0]     level_key [2][BOOK_LEVELS];
	logic [SIZE_W-1:0]      level_size [2][BOOK_LEVELS];
	bit                     level_live [2][BOOK_LEVELS];
	logic [PRICE_W-1:0]     key_pool [KEY_POOL_N];
	book_result_t           pending_results [$];
	int                     error_count = 0;
	int                     cycle_count = 0;
	int                     burst_left = 1;
	bit                     random_started = 1'b0;

	price_level_book_update uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.book_side    (book_side),
		.price        (price),
		.quantity     (quantity),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.found        (found),
		.found_size   (found_size),
		.level_count  (level_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic book_result_t apply_book_word(logic k, logic [1:0] sd,
			logic [PRICE_W-1:0] px, logic [SIZE_W-1:0] qty);
		book_result_t r;
		int s;
		int hit;
		int free_slot;
		int live;
		r = '{ST_IGNORED, 1'b0, '0, '0};
		if (sd != SIDE_BID && sd != SIDE_ASK)
			return r;
		s = (sd == SIDE_ASK) ? 1 : 0;
		hit = -1;
		free_slot = -1;
		for (int i = 0; i < BOOK_LEVELS; i++) begin
			if (level_live[s][i]) begin
				if (hit < 0 && level_key[s][i] == px)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (hit >= 0) begin
			r.fnd = 1'b1;
			r.fsize = level_size[s][hit];
		end
		if (k == KIND_LOOKUP) begin
			r.st = ST_LOOKUP;
		end else if (qty == '0) begin
			if (hit >= 0) begin
				level_live[s][hit] = 1'b0;
				r.st = ST_DELETED;
			end else begin
				r.st = ST_ABSENT;
			end
		end else if (hit >= 0) begin
			level_size[s][hit] = qty;
			r.st = ST_UPDATED;
		end else if (free_slot >= 0) begin
			level_key[s][free_slot] = px;
			level_size[s][free_slot] = qty;
			level_live[s][free_slot] = 1'b1;
			r.st = ST_INSERTED;
		end else begin
			r.st = ST_FULL;
		end
		live = 0;
		for (int i = 0; i < BOOK_LEVELS; i++)
			if (level_live[s][i])
				live++;
		r.cnt = live[COUNT_W-1:0];
		return r;
	endfunction

	task automatic send_word(logic k, logic [1:0] sd, logic [PRICE_W-1:0] px,
			logic [SIZE_W-1:0] qty, logic typed, book_result_t typed_res);
		book_result_t predicted;
		item_valid <= 1'b1;
		kind <= k;
		book_side <= sd;
		price <= px;
		quantity <= qty;
		do
			@(posedge clk);
		while (item_stall);
		predicted = apply_book_word(k, sd, px, qty);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic pace_sender();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 48);
			gap = $urandom_range(0, 7);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		logic k;
		logic [1:0] sd;
		logic [1:0] tgt;
		logic [1:0] alt;
		logic [PRICE_W-1:0] px;
		logic [SIZE_W-1:0] qty;
		int roll;
		int zero_pct;
		bit fill;
		for (int i = 0; i < KEY_POOL_N; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_N; i++) begin
			send_word(DIR_ROWS[i].k, DIR_ROWS[i].sd, DIR_ROWS[i].px, DIR_ROWS[i].qty,
				DIR_ROWS[i].typed, DIR_ROWS[i].res);
			pace_sender();
		end
		random_started = 1'b1;
		for (int p = 0; p < RAND_PHASES; p++) begin
			fill = (p % 2 == 0);
			zero_pct = fill ? 10 : 65;
			tgt = $urandom_range(0, 1) ? SIDE_ASK : SIDE_BID;
			alt = (tgt == SIDE_BID) ? SIDE_ASK : SIDE_BID;
			for (int j = 0; j < PHASE_WORDS; j++) begin
				k = ($urandom_range(0, 99) < 15) ? KIND_LOOKUP : KIND_UPDATE;
				roll = $urandom_range(0, 99);
				if (roll < 5)
					sd = $urandom_range(0, 1) ? SIDE_OTHER_HI : SIDE_OTHER_LO;
				else if (roll < 85)
					sd = tgt;
				else
					sd = alt;
				if ($urandom_range(0, 99) < 6)
					px = $urandom;
				else
					px = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
				roll = $urandom_range(0, 99);
				if (roll < zero_pct)
					qty = '0;
				else if (roll < zero_pct + 5)
					qty = '1;
				else if (roll < zero_pct + 8)
					qty = 1;
				else
					qty = $urandom;
				send_word(k, sd, px, qty, 1'b0, '0);
				pace_sender();
			end
		end
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int seg;
		int pct;
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			if (random_started && !hold_done) begin
				hold_done = 1'b1;
				for (int c = 0; c < HOLD_CYCLES; c++) begin
					@(posedge clk);
					result_stall <= 1'b1;
				end
			end
			seg = $urandom_range(10, 150);
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 25;
				2: pct = 60;
				default: pct = 90;
			endcase
			repeat (seg) begin
				@(posedge clk);
				result_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	always @(posedge clk) begin
		book_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with no pending expectation");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					error_count++;
				end
				if (found !== want.fnd) begin
					$error("found: expected %0d, got %0d", want.fnd, found);
					error_count++;
				end
				if (found_size !== want.fsize) begin
					$error("found_size: expected %h, got %h", want.fsize, found_size);
					error_count++;
				end
				if (level_count !== want.cnt) begin
					$error("level_count: expected %0d, got %0d", want.cnt, level_count);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
